FILE: src/reversible_stack_unit_assert.svh
// Assertion macros used by the top file of the reversible stack unit.
`ifndef REVERSIBLE_STACK_UNIT_ASSERT_SVH
`define REVERSIBLE_STACK_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rsu_pkg.sv
// Shared types and constants of the reversible stack unit.
package rsu_pkg;

  localparam int KIND_W    = 3;
  localparam int WORD_W    = 32;
  localparam int FILL_W    = 6;
  localparam int DEPTH_DEF = 32;

  localparam logic [KIND_W-1:0] K_PUSH    = 3'd0;
  localparam logic [KIND_W-1:0] K_POP     = 3'd1;
  localparam logic [KIND_W-1:0] K_REVERSE = 3'd2;
  localparam logic [KIND_W-1:0] K_DISPLAY = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TOP,
    S_CAP,
    S_DLOAD,
    S_DOUT,
    S_DADDR,
    S_OUT
  } rsu_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the request
    logic exec;       // apply the request to the stack state
    logic cap_top;    // capture top word, fill and empty flag
    logic load_res;   // load the single result of a non-display request or an empty display
    logic load_disp;  // load one display result from the read port
    logic addr_k;     // read at the display cursor instead of the top
    logic k_inc;      // advance the display cursor
  } rsu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_disp;    // captured request is a display
    logic empty;      // no words held
    logic res_last;   // result register holds the final result
  } rsu_sts_t;

endpackage

FILE: src/rsu_if.sv
// Request and result channel interfaces of the reversible stack unit.
interface rsu_in_if import rsu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface rsu_out_if import rsu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data;
  logic                     has_data;
  logic signed [WORD_W-1:0] top_word;
  logic                     is_empty;
  logic [FILL_W-1:0]        fill;
  logic                     overflow;
  logic                     last;

  modport source (output valid, data, has_data, top_word, is_empty, fill, overflow, last,
                  input ready);
  modport sink (input valid, data, has_data, top_word, is_empty, fill, overflow, last,
                output ready);
endinterface

FILE: src/reversible_stack_unit.sv
// Every request runs through EXEC, TOP and CAP; a non-display request or a display of
// an empty stack then shows its one result in OUT, while any other display shows each
// word in DOUT after a read in DLOAD, with a DADDR step between taken words, set by the
// single registered read port of the ring store. A new request waits until the last result is taken.
// Reset (synchronous, rst_n low): empty stack, base 0, normal direction, idle; the
// store itself is not cleared and needs no clearing pass.
`include "reversible_stack_unit_assert.svh"
module reversible_stack_unit import rsu_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rsu_in_if.sink    in_chan,
  rsu_out_if.source out_chan
);

  // Command and status between the sequencer and the datapath.
  rsu_cmd_t cmd;
  rsu_sts_t sts;

  // Sequencer: take one request, run it through the store, hand out its results.
  rsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: ring store with direction bit; the result register stays put while
  // a result waits, so a stalled sink sees a stable payload.
  rsu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_kind      (in_chan.kind),
    .in_value     (in_chan.value),
    .sts          (sts),
    .out_data     (out_chan.data),
    .out_has_data (out_chan.has_data),
    .out_top_word (out_chan.top_word),
    .out_is_empty (out_chan.is_empty),
    .out_fill     (out_chan.fill),
    .out_overflow (out_chan.overflow),
    .out_last     (out_chan.last)
  );

  // A new request is never taken while a result is pending.
  `RSU_ASSERT_NOW(a_no_overlap, out_chan.valid, !in_chan.ready,
    "request taken while a result is pending")

  // An accepted request is never answered in the very next cycle.
  `RSU_ASSERT_NEXT(a_accept_gap, in_chan.valid && in_chan.ready, !out_chan.valid,
    "result shown too early after a request")

  // A dropped push carries no word and closes its request.
  `RSU_ASSERT_NOW(a_ovf_shape, out_chan.valid && out_chan.overflow,
    !out_chan.has_data && out_chan.last, "overflow result carries data or is not last")

endmodule

FILE: src/rsu_ctrl.sv
// Controller state machine of the reversible stack unit.
module rsu_ctrl import rsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rsu_sts_t sts,
  output rsu_cmd_t cmd
);

  rsu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.cap_top = 1'b1;
        if (sts.is_disp && !sts.empty) begin
          cmd.addr_k = 1'b1;
          state_nxt  = S_DLOAD;
        end else begin
          cmd.load_res = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_DLOAD: begin
        cmd.load_disp = 1'b1;
        state_nxt     = S_DOUT;
      end
      S_DOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.res_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_DADDR;
          end
        end
      end
      S_DADDR: begin
        cmd.addr_k = 1'b1;
        state_nxt  = S_DLOAD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rsu_dp.sv
// Datapath of the reversible stack unit: ring store, pointers and result register.
module rsu_dp import rsu_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rsu_cmd_t                 cmd,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [WORD_W-1:0] in_value,
  output rsu_sts_t                 sts,
  output logic signed [WORD_W-1:0] out_data,
  output logic                     out_has_data,
  output logic signed [WORD_W-1:0] out_top_word,
  output logic                     out_is_empty,
  output logic [FILL_W-1:0]        out_fill,
  output logic                     out_overflow,
  output logic                     out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  // Wrap a sum below twice the depth back into the ring.
  function automatic addr_t wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= (AW+1)'(DEPTH)) ? s - (AW+1)'(DEPTH) : s;
    return t[AW-1:0];
  endfunction

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;

  addr_t             base_r, base_nxt;
  cnt_t              held_r, held_nxt;
  logic              rev_r, rev_nxt;
  addr_t             k_r;
  logic [KIND_W-1:0] kind_r;
  logic [WORD_W-1:0] value_r;
  logic              res_has_r;
  logic [WORD_W-1:0] res_word_r;
  logic              res_ovf_r;

  logic  full, empty, disp_last;
  logic  wr_en;
  addr_t wr_addr, base_dec, rd_addr, k_sel;
  cnt_t  off_c;

  assign full      = (held_r == CW'(DEPTH));
  assign empty     = (held_r == '0);
  assign disp_last = ((CW'(k_r) + CW'(1)) == held_r);
  assign base_dec  = (base_r == '0) ? AW'(DEPTH - 1) : base_r - AW'(1);

  // Slot of the word k places below the top.
  assign k_sel   = cmd.addr_k ? k_r : '0;
  assign off_c   = rev_r ? CW'(k_sel) : held_r - CW'(1) - CW'(k_sel);
  assign rd_addr = wrap({1'b0, base_r} + (AW+1)'(off_c[AW-1:0]));

  always_comb begin
    base_nxt = base_r;
    held_nxt = held_r;
    rev_nxt  = rev_r;
    wr_en    = 1'b0;
    wr_addr  = wrap({1'b0, base_r} + (AW+1)'(held_r));
    if (cmd.exec) begin
      unique case (kind_r)
        K_PUSH: begin
          if (!full) begin
            wr_en    = 1'b1;
            held_nxt = held_r + CW'(1);
            if (rev_r) begin
              base_nxt = base_dec;
              wr_addr  = base_dec;
            end
          end
        end
        K_POP: begin
          if (!empty) begin
            held_nxt = held_r - CW'(1);
            if (rev_r) begin
              base_nxt = wrap({1'b0, base_r} + (AW+1)'(1));
            end
          end
        end
        K_REVERSE: begin
          rev_nxt = !rev_r;
        end
        K_CLEAR: begin
          base_nxt = '0;
          held_nxt = '0;
          rev_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      held_r <= '0;
      rev_r  <= 1'b0;
      k_r    <= '0;
    end else begin
      base_r <= base_nxt;
      held_r <= held_nxt;
      rev_r  <= rev_nxt;
      if (cmd.exec) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      res_has_r  <= (kind_r == K_POP) && !empty;
      res_word_r <= rd_q;
      res_ovf_r  <= (kind_r == K_PUSH) && full;
    end
    if (cmd.cap_top) begin
      out_top_word <= empty ? '0 : rd_q;
      out_fill     <= FILL_W'(held_r);
      out_is_empty <= empty;
    end
    if (cmd.load_res) begin
      out_data     <= res_has_r ? res_word_r : '0;
      out_has_data <= res_has_r;
      out_overflow <= res_ovf_r;
      out_last     <= 1'b1;
    end else if (cmd.load_disp) begin
      out_data     <= rd_q;
      out_has_data <= 1'b1;
      out_overflow <= 1'b0;
      out_last     <= disp_last;
    end
  end

  assign sts.is_disp  = (kind_r == K_DISPLAY);
  assign sts.empty    = empty;
  assign sts.res_last = out_last;

endmodule

FILE: tb/tb_reversible_stack_unit.sv
// Self-checking testbench for the reversible stack unit: directed and random requests.
`timescale 1ns / 1ps

module tb_reversible_stack_unit;
  import rsu_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  // Kind codes the block does not decode; each still yields one status result.
  localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_ZERO = '0;
  localparam logic signed [WORD_W-1:0] WORD_ONES = '1;

  // One result as the block reports it.
  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic                     has_data;
    logic signed [WORD_W-1:0] top_word;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill;
    logic                     overflow;
    logic                     last;
  } stack_result_t;

  logic clk;
  logic rst_n;

  rsu_in_if  in_chan ();
  rsu_out_if out_chan ();

  reversible_stack_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // Shadow stack: ring store, base slot, word count and direction bit.
  logic signed [WORD_W-1:0] shadow_ring [DEPTH];
  int                       shadow_base;
  int                       shadow_held;
  bit                       shadow_rev;

  // Results the block still owes, oldest first.
  stack_result_t pending_results[$];

  bit src_idle_on;
  bit sink_idle_on;
  int requests_sent;
  int results_checked;
  int dropped_pushes;
  int longest_listing;
  int mismatch_count;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow stack
  // ---------------------------------------------------------------------------

  // Ring slot of the word k places below the top (k < shadow_held).
  function automatic int slot_below_top(int k);
    if (shadow_rev)
      return (shadow_base + k) % DEPTH;
    return (shadow_base + shadow_held - 1 - k) % DEPTH;
  endfunction

  // Build one result from the stack state as it stands after the request.
  function automatic stack_result_t status_result(logic signed [WORD_W-1:0] data,
                                                  logic has, logic ovf, logic fin);
    stack_result_t r;
    r.data     = data;
    r.has_data = has;
    r.top_word = (shadow_held != 0) ? shadow_ring[slot_below_top(0)] : WORD_ZERO;
    r.is_empty = (shadow_held == 0);
    r.fill     = FILL_W'(shadow_held);
    r.overflow = ovf;
    r.last     = fin;
    return r;
  endfunction

  // Apply one accepted request to the shadow stack and queue what it must produce.
  function automatic void apply_request(logic [KIND_W-1:0] kind,
                                        logic signed [WORD_W-1:0] value);
    logic signed [WORD_W-1:0] word;
    case (kind)
      K_PUSH: begin
        if (shadow_held >= DEPTH) begin
          // Full: drop the word, flag overflow, leave the stack alone.
          dropped_pushes++;
          pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b1, 1'b1));
        end else begin
          if (shadow_rev) begin
            shadow_base = (shadow_base + DEPTH - 1) % DEPTH;
            shadow_ring[shadow_base] = value;
          end else begin
            shadow_ring[(shadow_base + shadow_held) % DEPTH] = value;
          end
          shadow_held++;
          pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b0, 1'b1));
        end
      end
      K_POP: begin
        if (shadow_held == 0) begin
          pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b0, 1'b1));
        end else begin
          word = shadow_ring[slot_below_top(0)];
          if (shadow_rev)
            shadow_base = (shadow_base + 1) % DEPTH;
          shadow_held--;
          pending_results.push_back(status_result(word, 1'b1, 1'b0, 1'b1));
        end
      end
      K_REVERSE: begin
        shadow_rev = !shadow_rev;
        pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b0, 1'b1));
      end
      K_DISPLAY: begin
        // List top to bottom; an empty stack gives one wordless result.
        if (shadow_held == 0) begin
          pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b0, 1'b1));
        end else begin
          for (int k = 0; k < shadow_held; k++)
            pending_results.push_back(status_result(shadow_ring[slot_below_top(k)],
                                                    1'b1, 1'b0, k + 1 == shadow_held));
          if (shadow_held > longest_listing)
            longest_listing = shadow_held;
        end
      end
      K_CLEAR: begin
        shadow_held = 0;
        shadow_base = 0;
        shadow_rev  = 1'b0;
        pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        pending_results.push_back(status_result(WORD_ZERO, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request: hold off a random gap if source idling is on, then hold valid until accepted.
  // Leave valid high on return so back-to-back requests need no extra edge.
  task automatic send_request(logic [KIND_W-1:0] kind, logic signed [WORD_W-1:0] value);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind  <= kind;
    in_chan.value <= value;
    do @(posedge clk); while (!in_chan.ready);
    requests_sent++;
    apply_request(kind, value);
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return WORD_ZERO;
      3:       return WORD_ONES;
      4:       return WORD_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return K_PUSH;
    if (r < 70) return K_POP;
    if (r < 78) return K_REVERSE;
    if (r < 89) return K_DISPLAY;
    if (r < 94) return K_CLEAR;
    return K_SPARE_FIRST + KIND_W'($urandom_range(0, K_SPARE_LAST - K_SPARE_FIRST));
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // When sink idling is on, stall for a random gap before each result, then hold ready until one is taken.
  initial begin : result_sink
    int stall;
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_chan.valid));
    end
  end

  function automatic void compare_field(string fname, logic [WORD_W-1:0] exp_v,
                                        logic [WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", fname, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Compare every taken result with the oldest owed one.
  always @(posedge clk) begin : result_check
    stack_result_t exp_r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing owed: data %0h last %0b", out_chan.data, out_chan.last);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("data", exp_r.data, out_chan.data);
        compare_field("has_data", WORD_W'(exp_r.has_data), WORD_W'(out_chan.has_data));
        compare_field("top_word", exp_r.top_word, out_chan.top_word);
        compare_field("is_empty", WORD_W'(exp_r.is_empty), WORD_W'(out_chan.is_empty));
        compare_field("fill", WORD_W'(exp_r.fill), WORD_W'(out_chan.fill));
        compare_field("overflow", WORD_W'(exp_r.overflow), WORD_W'(out_chan.overflow));
        compare_field("last", WORD_W'(exp_r.last), WORD_W'(out_chan.last));
        results_checked++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands on an empty stack, including the undecoded kind codes.
  task automatic test_empty_stack();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_request(K_POP, WORD_ONES);
    send_request(K_DISPLAY, WORD_MAX);
    send_request(K_REVERSE, WORD_ZERO);
    send_request(K_POP, WORD_MIN);
    send_request(K_REVERSE, WORD_ZERO);
    send_request(K_CLEAR, WORD_ONES);
    send_request(K_SPARE_FIRST, WORD_MAX);
    send_request(K_SPARE_FIRST + 3'd1, WORD_MIN);
    send_request(K_SPARE_LAST, WORD_ONES);
  endtask

  // Word extremes, listing in both directions, and push/pop while reversed.
  task automatic test_word_extremes();
    send_request(K_PUSH, WORD_MAX);
    send_request(K_PUSH, WORD_MIN);
    send_request(K_PUSH, WORD_ZERO);
    send_request(K_PUSH, WORD_ONES);
    send_request(K_DISPLAY, WORD_ZERO);
    send_request(K_REVERSE, WORD_ZERO);
    send_request(K_DISPLAY, WORD_ZERO);
    send_request(K_PUSH, 32'sh5A5A_A5A5);
    send_request(K_POP, WORD_ZERO);
    send_request(K_POP, WORD_ZERO);
    send_request(K_REVERSE, WORD_ZERO);
    send_request(K_POP, WORD_ZERO);
    send_request(K_CLEAR, WORD_ZERO);
    send_request(K_POP, WORD_ZERO);
    send_request(K_DISPLAY, WORD_ZERO);
  endtask

  // Weighted random traffic; pick idling on each side anew every 40 requests.
  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        src_idle_on  = $urandom_range(0, 1);
        sink_idle_on = $urandom_range(0, 1);
      end
      send_request(random_kind(), random_word());
    end
  endtask

  // Fill to full, push past full, list the full stack both ways, then empty it.
  task automatic test_fill_overflow();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_request(K_CLEAR, WORD_ZERO);
    while (shadow_held < DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        send_request(K_REVERSE, WORD_ZERO);
      else
        send_request(K_PUSH, random_word());
    end
    repeat (3) send_request(K_PUSH, random_word());
    send_request(K_DISPLAY, WORD_ZERO);
    send_request(K_REVERSE, WORD_ZERO);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_request(K_DISPLAY, WORD_ZERO);
    send_request(K_PUSH, random_word());
    while (shadow_held > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_request(K_PUSH, random_word());
      else
        send_request(K_POP, random_word());
    end
    send_request(K_POP, WORD_ZERO);
  endtask

  // Walk the base slot around the ring in reversed direction.
  task automatic test_ring_wrap();
    int n;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    send_request(K_CLEAR, WORD_ZERO);
    send_request(K_REVERSE, WORD_ZERO);
    for (int round = 0; round < 7; round++) begin
      if (round == 4) sink_idle_on = 1'b1;
      n = $urandom_range(3, 12);
      repeat (n) send_request(K_PUSH, random_word());
      if ($urandom_range(0, 1)) send_request(K_DISPLAY, WORD_ZERO);
      n = $urandom_range(1, shadow_held);
      repeat (n) send_request(K_POP, WORD_ZERO);
      if ($urandom_range(0, 3) == 0) send_request(K_REVERSE, WORD_ZERO);
    end
    send_request(K_DISPLAY, WORD_ZERO);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow_base = 0;
    shadow_held = 0;
    shadow_rev  = 1'b0;
    foreach (shadow_ring[i]) shadow_ring[i] = WORD_ZERO;
    src_idle_on     = 1'b0;
    sink_idle_on    = 1'b0;
    requests_sent   = 0;
    results_checked = 0;
    dropped_pushes  = 0;
    longest_listing = 0;
    mismatch_count  = 0;
    cycle_count     = 0;

    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.kind  <= K_PUSH;
    in_chan.value <= WORD_ZERO;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_word_extremes();
    test_random_mix(90);
    // Let the block go fully quiet before the long fill run.
    wait_results_drained();
    test_fill_overflow();
    test_ring_wrap();
    test_random_mix(90);

    wait_results_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d results; %0d pushes dropped on a full stack",
             requests_sent, results_checked, dropped_pushes);
    $display("longest listing %0d words, %0d mismatches", longest_listing, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
